[hw/rtl/slsps_pkg.sv]
// package: constants, types and helpers for the sound port pitch slew block
`timescale 1ns / 1ps

package slsps_pkg;

  localparam int NUM_SLOTS   = 9;
  localparam int SLOT_W      = 4;
  localparam int PITCH_W     = 18;
  localparam int FRAME_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 18'h20000;
  localparam logic [PITCH_W-1:0] PITCH_BASE  = 18'h10000;
  localparam logic [PITCH_W-1:0] SLEW_DOWN   = 18'd300;
  localparam logic [PITCH_W-1:0] SLEW_UP     = 18'd200;
  localparam logic [7:0]         SHIFT_RESET = 8'hFF;

  // command codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_FREQ  = 2'd2;

  // command slots, in emission order
  localparam logic [SLOT_W-1:0] SLOT_START2 = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_START5 = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_CH6    = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_CH7    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_CH4    = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_FREQ   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_START3 = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_START1 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_START0 = 4'd8;

  // one classified port write: which commands, the latched polarity of
  // register bits 2..4 and the slewed pitch
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [2:0]           pol;
    logic [PITCH_W-1:0]   pitch;
  } cmd_entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic       push;
    cmd_entry_t data;
  } push_req_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t data;
  } pop_head_t;

  function automatic logic [SLOT_W-1:0] first_slot(input logic [NUM_SLOTS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

[hw/rtl/slsps_in_if.sv]
// interface: sound port write channel
`timescale 1ns / 1ps

interface slsps_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  port_value;
  logic [7:0]  changed_bits;
  logic [31:0] frame_number;

  modport source (output valid, output port_value, output changed_bits,
                  output frame_number, input ready);
  modport sink (input valid, input port_value, input changed_bits,
                input frame_number, output ready);
endinterface

[hw/rtl/slsps_out_if.sv]
// interface: sample player command channel
`timescale 1ns / 1ps

interface slsps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  channel;
  logic [2:0]  sample_id;
  logic        looping;
  logic [17:0] frequency;
  logic        last;

  modport source (output valid, output action, output channel, output sample_id,
                  output looping, output frequency, output last, input ready);
  modport sink (input valid, input action, input channel, input sample_id,
                input looping, input frequency, input last, output ready);
endinterface

[hw/rtl/shift_latch_sound_pitch_slew.sv]
// top level: sound port decoder with shift latch and slewing drone pitch
//
//   channel  | dir | payload                                          | accepted when
//   ---------+-----+--------------------------------------------------+------------------
//   in_ch    | in  | port_value, changed_bits, frame_number           | valid && ready
//   out_ch   | out | action, channel, sample_id, looping, frequency,  | valid && ready
//            |     | last                                             |
//
// cycles: one port write accepted per cycle while the queue has room; the back
//   emits one command per cycle while out_ch is not stalled; a write carries 0 to 9 commands
// a write that causes no command updates state and takes no queue slot
// reset: rst_n low restores shift/latch registers, pitch, slew frame; empties queue
// stalls: out_ch.ready low holds the output register and the back's entry; the
//   queue fills and in_ch.ready drops once it is full
`timescale 1ns / 1ps

module shift_latch_sound_pitch_slew #(
  parameter int QUEUE_DEPTH = slsps_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  slsps_in_if.sink    in_ch,
  slsps_out_if.source out_ch
);

  // front to queue
  slsps_pkg::push_req_t push_req;
  logic                 q_full;
  // queue to back
  slsps_pkg::pop_head_t head;
  logic                 pop;

  // decoder: edge detect, shift register, latch compare, pitch slew
  slsps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push_req (push_req),
    .q_full   (q_full)
  );

  // classified writes waiting for the emitter
  slsps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  // emitter: walks the slot mask in order, marks the final command
  slsps_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[hw/rtl/slsps_fifo.sv]
// module: short command queue between the decoder front and the emitter back
`timescale 1ns / 1ps

module slsps_fifo #(
  parameter int DEPTH = slsps_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slsps_pkg::push_req_t  push_req,
  output logic                  full,
  input  logic                  pop,
  output slsps_pkg::pop_head_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  slsps_pkg::cmd_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign do_push    = push_req.push && !full;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_req.data;
  end

endmodule

[hw/rtl/slsps_front.sv]
// module: port write decoder, shift register, latch and pitch slew state
`timescale 1ns / 1ps

module slsps_front (
  input  logic                 clk,
  input  logic                 rst_n,
  slsps_in_if.sink             in_ch,
  output slsps_pkg::push_req_t push_req,
  input  logic                 q_full
);

  localparam int PW = slsps_pkg::PITCH_W;

  logic [7:0]    shift_r, shift_nxt;
  logic [7:0]    latched_r;
  logic [PW-1:0] pitch_r;
  logic [31:0]   slew_frame_r;

  logic [7:0]    fall;
  logic [7:0]    diff;
  logic          strobe, slew, accept;
  logic [3:0]    tgt_sel;
  logic [PW-1:0] target, pitch_dn, pitch_nxt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // falling edge: changed and now low
  assign fall      = in_ch.changed_bits & ~in_ch.port_value;
  assign shift_nxt = fall[4] ? {shift_r[6:0], in_ch.port_value[7]} : shift_r;
  assign strobe    = fall[0];
  assign diff      = shift_nxt ^ latched_r;
  assign slew      = strobe && (in_ch.frame_number > slew_frame_r);

  assign tgt_sel   = {shift_nxt[6], shift_nxt[5], shift_nxt[6], shift_nxt[7]};
  assign target    = slsps_pkg::PITCH_BASE + (PW'(tgt_sel) << 12);
  assign pitch_dn  = (pitch_r > target) ? pitch_r - slsps_pkg::SLEW_DOWN : pitch_r;
  assign pitch_nxt = (pitch_dn < target) ? pitch_dn + slsps_pkg::SLEW_UP : pitch_dn;

  always_comb begin
    push_req.data.mask = '0;
    push_req.data.mask[slsps_pkg::SLOT_START2] = strobe && diff[0] && !shift_nxt[0];
    push_req.data.mask[slsps_pkg::SLOT_START5] = strobe && diff[1] && !shift_nxt[1];
    push_req.data.mask[slsps_pkg::SLOT_CH6]    = strobe && diff[2];
    push_req.data.mask[slsps_pkg::SLOT_CH7]    = strobe && diff[3];
    push_req.data.mask[slsps_pkg::SLOT_CH4]    = strobe && diff[4];
    push_req.data.mask[slsps_pkg::SLOT_FREQ]   = slew;
    push_req.data.mask[slsps_pkg::SLOT_START3] = fall[3];
    push_req.data.mask[slsps_pkg::SLOT_START1] = fall[2];
    push_req.data.mask[slsps_pkg::SLOT_START0] = fall[1];
    push_req.data.pol   = shift_nxt[4:2];
    push_req.data.pitch = pitch_nxt;
    push_req.push       = accept && (push_req.data.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= slsps_pkg::SHIFT_RESET;
      latched_r    <= slsps_pkg::SHIFT_RESET;
      pitch_r      <= slsps_pkg::PITCH_RESET;
      slew_frame_r <= '0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      if (strobe) latched_r <= shift_nxt;
      if (slew) begin
        pitch_r      <= pitch_nxt;
        slew_frame_r <= in_ch.frame_number;
      end
    end
  end

endmodule

[hw/rtl/slsps_back.sv]
// module: command emitter, one command per cycle from the queued slot mask while out_ch is not stalled
`timescale 1ns / 1ps

module slsps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slsps_pkg::pop_head_t head,
  output logic                 pop,
  slsps_out_if.source          out_ch
);

  localparam int NS = slsps_pkg::NUM_SLOTS;
  localparam int PW = slsps_pkg::PITCH_W;

  slsps_pkg::cmd_entry_t work_r;
  logic                  busy_r;
  logic                  out_valid_r;
  logic [1:0]            act_r;
  logic [2:0]            chan_r, id_r;
  logic                  loop_r, last_r;
  logic [PW-1:0]         freq_r;

  logic                      adv, send, is_last;
  logic [slsps_pkg::SLOT_W-1:0] idx;
  logic [NS-1:0]             rem;
  logic [1:0]                act_c;
  logic [2:0]                chan_c, id_c;
  logic                      loop_c;
  logic [PW-1:0]             freq_c;

  assign adv     = !out_valid_r || out_ch.ready;
  assign send    = adv && busy_r;
  assign idx     = slsps_pkg::first_slot(work_r.mask);
  assign rem     = work_r.mask & (work_r.mask - NS'(1));
  assign is_last = (rem == '0);
  assign pop     = head.valid && (!busy_r || (send && is_last));

  always_comb begin
    act_c  = slsps_pkg::ACT_START;
    chan_c = '0;
    id_c   = '0;
    loop_c = 1'b0;
    freq_c = '0;
    unique case (idx)
      slsps_pkg::SLOT_START2: begin chan_c = 3'd2; id_c = 3'd2; end
      slsps_pkg::SLOT_START5: begin chan_c = 3'd5; id_c = 3'd5; end
      slsps_pkg::SLOT_CH6: begin
        chan_c = 3'd6;
        if (work_r.pol[0]) begin
          id_c = 3'd6; loop_c = 1'b1;
        end else begin
          act_c = slsps_pkg::ACT_STOP;
        end
      end
      slsps_pkg::SLOT_CH7: begin
        chan_c = 3'd7;
        if (work_r.pol[1]) begin
          act_c = slsps_pkg::ACT_STOP;
        end else begin
          id_c = 3'd7; loop_c = 1'b1;
        end
      end
      slsps_pkg::SLOT_CH4: begin
        chan_c = 3'd4;
        if (work_r.pol[2]) begin
          act_c = slsps_pkg::ACT_STOP;
        end else begin
          id_c = 3'd4; loop_c = 1'b1;
        end
      end
      slsps_pkg::SLOT_FREQ: begin
        act_c = slsps_pkg::ACT_FREQ; chan_c = 3'd4; freq_c = work_r.pitch;
      end
      slsps_pkg::SLOT_START3: begin chan_c = 3'd3; id_c = 3'd3; end
      slsps_pkg::SLOT_START1: begin chan_c = 3'd1; id_c = 3'd1; end
      slsps_pkg::SLOT_START0: begin chan_c = 3'd0; id_c = 3'd0; end
      default: begin chan_c = 3'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (send && is_last) begin
        busy_r <= 1'b0;
      end
      if (adv) out_valid_r <= send;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_r <= head.data;
    end else if (send) begin
      work_r.mask <= rem;
    end
    if (send) begin
      act_r  <= act_c;
      chan_r <= chan_c;
      id_r   <= id_c;
      loop_r <= loop_c;
      freq_r <= freq_c;
      last_r <= is_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.action    = act_r;
  assign out_ch.channel   = chan_r;
  assign out_ch.sample_id = id_r;
  assign out_ch.looping   = loop_r;
  assign out_ch.frequency = freq_r;
  assign out_ch.last      = last_r;

endmodule
